FILE: sv/half_precision_converter_macros.svh
// Assertion macros for the half precision converter checker
`ifndef HALF_PRECISION_CONVERTER_MACROS_SVH
`define HALF_PRECISION_CONVERTER_MACROS_SVH

// a property that must hold at every clock edge out of reset
`define HPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// non-overlapping implication: the consequent is checked on the next clock
`define HPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hpc_pkg.sv
`default_nettype none
package hpc_pkg;
    localparam int unsigned OperandWidth = 32;
    localparam logic FuncEncode = 1'b0;
    localparam logic FuncDecode = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [OperandWidth-1:0] operand;
    } req_t;

    typedef struct packed {
        logic [OperandWidth-1:0] result;
        logic                    overflowed;
    } rsp_t;
endpackage
`default_nettype wire

FILE: sv/hpc_stream_if.sv
`default_nettype none
interface hpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/hpc_convert.sv
`default_nettype none
// Combinational conversion for one request
module hpc_convert (
    input  wire hpc_pkg::req_t req,
    output hpc_pkg::rsp_t  rsp
);
    logic [7:0]  e32;
    logic [22:0] m23;
    logic        sgn;
    logic [15:0] mag;
    logic [15:0] enc;
    logic        enc_ovf;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [24:0] rnd;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  lead;
    logic [31:0] dec;
    logic [9:0]  norm_m;

    assign e32 = req.operand[30:23];
    assign m23 = req.operand[22:0];
    assign sgn = req.operand[31];
    assign sig = {1'b1, m23};
    assign sh  = 5'(8'd126 - e32);
    // half-up rounding of the shifted significand (sh is 14..25 here)
    assign rnd = ({1'b0, sig} + (25'd1 << (sh - 5'd1))) >> sh;

    always_comb
    begin
        enc_ovf = 1'b0;
        mag     = '0;
        enc     = '0;
        if (e32 == 8'hFF)
        begin
            enc_ovf = 1'b1;
            enc     = (m23 != '0) ? 16'h7C00 : {sgn, 15'h7C00};
        end
        else if (e32 == 8'd0)
        begin
            enc = (m23 == '0) ? 16'h0000 : {sgn, 15'd0};
        end
        else if (e32 >= 8'd143)
        begin
            enc_ovf = 1'b1;
            enc     = {sgn, 15'h7C00};
        end
        else
        begin
            if (e32 > 8'd112)
                mag = {1'b0, 5'(e32 - 8'd112), 10'd0} + 16'((24'(m23) + 24'h1000) >> 13);
            else if (e32 < 8'd101)
                mag = '0;
            else
                mag = 16'(rnd);
            if (mag >= 16'h7C00)
            begin
                enc_ovf = 1'b1;
                mag     = 16'h7C00;
            end
            enc = {sgn, 15'd0} | mag;
        end
    end

    assign he = req.operand[14:10];
    assign hm = req.operand[9:0];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (hm[i])
                lead = 4'(i);
        end
    end

    assign norm_m = 10'(hm << (4'd10 - lead));

    always_comb
    begin
        if (he == 5'd31)
            dec = (hm == '0) ? {req.operand[15], 31'h7F800000}
                             : {req.operand[15], 31'h7FC00000 | {8'd0, hm, 13'd0}};
        else if (he != 5'd0)
            dec = {req.operand[15], 8'(he) + 8'd112, hm, 13'd0};
        else if (hm == '0)
            dec = {req.operand[15], 31'd0};
        else
            dec = {req.operand[15], 8'(lead) + 8'd103, norm_m, 13'd0};
    end

    always_comb
    begin
        if (req.func == hpc_pkg::FuncDecode)
        begin
            rsp.result     = dec;
            rsp.overflowed = 1'b0;
        end
        else
        begin
            rsp.result     = {16'd0, enc};
            rsp.overflowed = enc_ovf;
        end
    end
endmodule
`default_nettype wire

FILE: sv/half_precision_converter.sv
// Pipeline: an accepted request is registered in the input register, converted, then held in the result register.
// Throughput: one request per cycle unless the output stalls, set by the single conversion stage.
// Both stages advance whenever the result register is empty or being taken.
// Reset: asynchronous active-low rst_n clears both valid flags; payloads are not reset.
`default_nettype none
module half_precision_converter (
    input wire clk,
    input wire rst_n,
    hpc_stream_if.sink   in_ch,
    hpc_stream_if.source out_ch
);
    hpc_pkg::req_t req_reg;
    logic          req_valid_reg;
    hpc_pkg::rsp_t rsp_reg;
    hpc_pkg::rsp_t rsp_next;
    logic          rsp_valid_reg;
    logic          advance;

    assign advance      = !rsp_valid_reg || out_ch.ready;
    assign in_ch.ready  = advance;
    assign out_ch.valid = rsp_valid_reg;
    assign out_ch.payload = rsp_reg;

    hpc_convert u_convert (
        .req (req_reg),
        .rsp (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            req_valid_reg <= in_ch.valid;
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            req_reg <= in_ch.payload;
            rsp_reg <= rsp_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/hpc_checker.sv
`default_nettype none
`include "half_precision_converter_macros.svh"
module hpc_checker (
    input wire           clk,
    input wire           rst_n,
    input wire           in_valid,
    input wire           in_ready,
    input wire           out_valid,
    input wire           out_ready,
    input wire [31:0]    out_result,
    input wire           out_overflowed
);
    `HPC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result), "result changed while stalled")
    // saturated encode gives infinity of either sign in the low half
    `HPC_ASSERT(a_ovf_inf, clk, rst_n, (out_valid && out_overflowed) |-> (out_result[31:16] == 16'd0 && out_result[14:0] == 15'h7C00), "overflow flag without infinity")
    `HPC_ASSERT(a_ready, clk, rst_n, (!out_valid) |-> in_ready, "input stalled with empty output")
    `HPC_ASSERT_NEXT(a_flow, clk, rst_n, in_valid && in_ready && out_ready, 1'b1, "flow check")
endmodule

bind half_precision_converter hpc_checker u_hpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_result     (out_ch.payload.result),
    .out_overflowed (out_ch.payload.overflowed)
);
`default_nettype wire

FILE: dv/half_precision_converter_checker.sv
`default_nettype none
module half_precision_converter_checker
    import hpc_pkg::*;
(
    input wire clk,
    input wire rst_n,
    hpc_stream_if.sink in_mon,
    hpc_stream_if.sink out_mon,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned taken_in,
    output int unsigned taken_out
);
    timeunit 1ns;
    timeprecision 1ps;

    rsp_t expected_q[$];

    function automatic rsp_t convert(input req_t req);
        rsp_t r;
        logic [7:0] e32;
        logic [22:0] m23;
        logic sgn;
        logic [31:0] mag;
        logic [31:0] sig;
        int unsigned sh;
        logic [4:0] he;
        logic [9:0] hm;
        int p;
        r = '0;
        if (req.func == FuncEncode) begin
            e32 = req.operand[30:23];
            m23 = req.operand[22:0];
            sgn = req.operand[31];
            if (e32 == 8'hFF) begin
                r.overflowed = 1'b1;
                r.result = (m23 != 0) ? 32'h7C00 : ({16'd0, sgn, 15'h7C00});
            end else if (e32 == 0 && m23 == 0) begin
                r.result = '0;
            end else if (e32 == 0) begin
                r.result = {16'd0, sgn, 15'd0};
            end else if (e32 >= 143) begin
                r.overflowed = 1'b1;
                r.result = {16'd0, sgn, 15'h7C00};
            end else begin
                if (e32 > 112) begin
                    mag = ((32'(e32) - 112) << 10) + ((32'(m23) + 32'h1000) >> 13);
                end else begin
                    sig = 32'(m23) | 32'h800000;
                    sh = 126 - e32;
                    mag = (sh > 25) ? 0 : ((sig + (32'd1 << (sh - 1))) >> sh);
                end
                if (mag >= 32'h7C00) begin
                    r.overflowed = 1'b1;
                    mag = 32'h7C00;
                end
                r.result = {16'd0, sgn, 15'd0} | mag;
            end
        end else begin
            sgn = req.operand[15];
            he = req.operand[14:10];
            hm = req.operand[9:0];
            if (he == 5'd31)
                r.result = (hm == 0) ? {sgn, 31'h7F800000}
                                     : ({sgn, 31'h7FC00000} | (32'(hm) << 13));
            else if (he != 0)
                r.result = {sgn, 8'(he + 112), hm, 13'd0};
            else if (hm == 0)
                r.result = {sgn, 31'd0};
            else begin
                p = 9;
                while (hm[p] == 1'b0)
                    p--;
                r.result = {sgn, 8'(p + 103), 23'((32'(hm) << (23 - p)) & 32'h7FFFFF)};
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n) begin
            mismatches <= 0;
            pending <= 0;
            taken_in <= 0;
            taken_out <= 0;
        end else begin
            if (in_mon.valid && in_mon.ready) begin
                expected_q.push_back(convert(in_mon.payload));
                taken_in <= taken_in + 1;
            end
            if (out_mon.valid && out_mon.ready) begin
                taken_out <= taken_out + 1;
                got = out_mon.payload;
                if (expected_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %h ovf %b", got.result, got.overflowed);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.result !== got.result || want.overflowed !== got.overflowed) begin
                        if (mismatches < 10)
                            $display("mismatch: exp %h/%b got %h/%b", want.result,
                                     want.overflowed, got.result, got.overflowed);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule
`default_nettype wire

FILE: dv/half_precision_converter_tb.sv
`default_nettype none
module half_precision_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hpc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int unsigned mismatches, pending, taken_in, taken_out;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit hold_off = 1'b0;
    int unsigned quiet = 0;

    hpc_stream_if #(.payload_t(req_t)) in_ch ();
    hpc_stream_if #(.payload_t(rsp_t)) out_ch ();

    half_precision_converter u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    half_precision_converter_checker u_chk (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .mismatches(mismatches), .pending(pending),
        .taken_in(taken_in), .taken_out(taken_out));

    always #1 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 5000) begin
            $display("watchdog: no progress");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays high after the request is taken so the next one can follow at once
    task automatic send_request(input logic fn, input logic [31:0] opnd);
        req_t req;
        req.func = fn;
        req.operand = opnd;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= req;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random single pattern biased towards interesting exponents
    function automatic logic [31:0] rand_single();
        logic [7:0] e;
        case ($urandom_range(5))
            0: e = 8'($urandom_range(255));
            1: e = 8'($urandom_range(100, 145));
            2: e = $urandom_range(1) ? 8'hFF : 8'h00;
            3: e = 8'd142;
            default: e = 8'($urandom_range(101, 142));
        endcase
        return {1'($urandom), e, 23'($urandom)};
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        int cnt;
        directed = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h80400000,
                     32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'hFFFFFFFF,
                     32'h477FE000, 32'h477FF000, 32'hC77FEFFF, 32'h33000000,
                     32'hB3000001, 32'h387FC000, 32'h38800000, 32'h3F800000};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_request(FuncEncode, directed[i]);
        foreach (directed[i])
            send_request(FuncDecode, {16'($urandom), directed[i][31:16]});
        send_request(FuncDecode, 32'hFFFF0001);
        send_request(FuncDecode, 32'h000003FF);
        send_request(FuncDecode, 32'h00007C01);

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                cnt = 0;
                while (cnt < 60) begin
                    @(posedge clk);
                    cnt++;
                end
                hold_off = 1'b0;
            end
            begin
                repeat (20) send_request(1'($urandom_range(1)), rand_single());
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
        join
        @(negedge clk);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 48; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 48; end
                3: begin send_idle_pct = 34; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            repeat (330) begin
                if ($urandom_range(1))
                    send_request(FuncEncode, rand_single());
                else
                    send_request(FuncDecode, $urandom);
            end
        end
        in_ch.valid <= 1'b0;
        recv_idle_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("%0d requests sent, %0d results checked: encode/decode extremes,",
                 taken_in, taken_out);
        $display("specials and random operands under varied back-pressure");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
